>>> hdl/gdad_pkg.sv
// Shared types and constants for the Gregorian date-plus-days unit.
// Holds the month length table, the controller/datapath command and status
// structs, and the controller state encoding. No dependencies.
package gdad_pkg;

  // Field widths
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 15;
  localparam int unsigned LeftW  = 16;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned RemW   = 7;
  localparam int unsigned ProdW  = 27;

  // Calendar constants
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   FebLeap  = 5'd29;
  localparam logic [DayW-1:0]   FebPlain = 5'd28;
  localparam logic [YearW-1:0]  YearMax  = 14'h3FFF;
  localparam logic [RemW-1:0]   RemLast  = 7'd99;

  // Reciprocal of 100 scaled by 2^19; exact floor for any 14-bit year
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam int unsigned RecipShift = 19;
  localparam logic [6:0]  Hundred   = 7'd100;

  // Length of a month; February follows the leap flag
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:    len = leap ? FebLeap : FebPlain;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic split_year;
    logic sum_step;
    logic walk_init;
    logic walk_step;
    logic finish;
  } gdad_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_done;
    logic walk_done;
  } gdad_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_WALK = 4'b1000
  } gdad_state_t;

endpackage

>>> hdl/gdad_datapath.sv
// Datapath of the Gregorian date-plus-days unit: year/month/remainder
// registers, leap test from year mod 100 tracking, and output register.
// Depends on gdad_pkg.
module gdad_datapath import gdad_pkg::*; (
  input  logic                clk,
  input  logic [39:0]         in_tdata,
  input  gdad_cmd_t           cmd,
  output gdad_stat_t          stat,
  output logic [23:0]         out_tdata
);

  logic [YearW-1:0]  year_r;
  logic [QuotW-1:0]  quot_r;
  logic [RemW-1:0]   rem_r;
  logic [ProdW-1:0]  prod_r;
  logic [MonthW-1:0] month_r;
  logic [MonthW-1:0] m_r;
  logic [LeftW-1:0]  left_r;
  logic [YearW-1:0]  out_year_r;
  logic [MonthW-1:0] out_month_r;
  logic [DayW-1:0]   out_day_r;

  logic [YearW-1:0]  in_year;
  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [CountW-1:0] in_count;
  logic [QuotW-1:0]  quot;
  logic [YearW-1:0]  hund_part;
  logic              leap;
  logic [DayW-1:0]   len;
  logic [LeftW-1:0]  len_ext;

  // Unpack the input beat
  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];
  assign in_count = in_tdata[37:23];

  // Split year into hundreds and remainder
  assign quot      = prod_r[ProdW-1:RecipShift];
  assign hund_part = YearW'(quot * Hundred);

  // Leap rule: century years need divisibility by 400
  assign leap    = (rem_r == '0) ? (quot_r[1:0] == 2'd0) : (year_r[1:0] == 2'd0);
  assign len     = month_len(m_r, leap);
  assign len_ext = {{(LeftW-DayW){1'b0}}, len};

  assign stat.sum_done  = (m_r >= month_r);
  assign stat.walk_done = (left_r <= len_ext);

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_year;
      prod_r  <= ProdW'(in_year * Recip100);
      month_r <= (in_month > MonthDec) ? MonthDec : in_month;
      m_r     <= MonthJan;
      left_r  <= LeftW'(in_day) + LeftW'(in_count);
    end
    if (cmd.split_year) begin
      quot_r <= quot;
      rem_r  <= RemW'(year_r - hund_part);
    end
    if (cmd.sum_step) begin
      left_r <= left_r + len_ext;
      m_r    <= m_r + MonthW'(1);
    end
    if (cmd.walk_init) begin
      m_r <= MonthJan;
    end
    if (cmd.walk_step) begin
      left_r <= left_r - len_ext;
      if (m_r == MonthDec) begin
        m_r <= MonthJan;
        // Advance the year, keeping mod-100 split in step
        if (year_r == YearMax) begin
          year_r <= '0;
          rem_r  <= '0;
          quot_r <= '0;
        end else begin
          year_r <= year_r + YearW'(1);
          if (rem_r == RemLast) begin
            rem_r  <= '0;
            quot_r <= quot_r + QuotW'(1);
          end else begin
            rem_r <= rem_r + RemW'(1);
          end
        end
      end else begin
        m_r <= m_r + MonthW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_year_r  <= year_r;
      out_month_r <= m_r;
      out_day_r   <= left_r[DayW-1:0];
    end
  end

  assign out_tdata = {1'b0, out_day_r, out_month_r, out_year_r};

endmodule

>>> hdl/gdad_ctrl.sv
// Controller of the Gregorian date-plus-days unit: sequences load, year
// split, day-of-year sum and month walk, and owns the handshakes.
// Depends on gdad_pkg.
module gdad_ctrl import gdad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  gdad_stat_t stat,
  output gdad_cmd_t  cmd
);

  gdad_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        can_finish;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign can_finish = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.split_year = 1'b1;
        state_nxt      = ST_SUM;
      end
      ST_SUM: begin
        if (stat.sum_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = ST_WALK;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (!stat.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (can_finish) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date-plus-days unit.
// Joins gdad_ctrl and gdad_datapath; depends on gdad_pkg.
//
// Usage:
//   Input channel in_*: one beat carries a start date and a day count.
//   Output channel out_*: one beat carries the resulting date.
//   Each input beat yields exactly one output beat, in order.
// Sequence:
//   One item is worked at a time. After acceptance the year is split into
//   hundreds, the lengths of the months before start_month are summed to
//   form the day of year, the walk restarts at January and subtracts one
//   month length per cycle, and the output register is loaded. out_tvalid
//   and in_tready both rise together once the output register is loaded,
//   so the next beat is taken only once the last result is in the output
//   register. A count of 32767 walks up to about 1090 months.
// Reset: rst_n (synchronous, active low) returns the controller to idle
//   and drops out_tvalid; no clearing pass is needed.
// Stall: a finished result waits in the output register. While it waits
//   the block takes and works the next item; that item's result holds in
//   the datapath until the output register is free.
module gregorian_date_add_days_unit import gdad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [37:23] days_to_add, [39:38] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] end_year, [17:14] end_month, [22:18] end_day, [23] zero
  output logic [23:0] out_tdata
);

  gdad_cmd_t  cmd;
  gdad_stat_t stat;

  gdad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  gdad_datapath u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

>>> tb/gregorian_date_add_days_unit_test.sv
// Self-checking testbench for gregorian_date_add_days_unit: drives date/day-count
// beats on in_*, predicts each resulting date in SystemVerilog, checks out_* beats.
// Depends on gdad_pkg and the unit under test; needs no files or arguments.
module gregorian_date_add_days_unit_test;
  import gdad_pkg::*;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned SettleCycles = 1200;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned NormCount    = 32000;
  localparam int unsigned MaxCount     = 32767;
  localparam int unsigned YearTop      = 9999;

  // Start date and count, laid out as in_tdata[37:0], year in the lowest bits
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_req_t;

  // Resulting date, laid out as out_tdata[22:0]
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cal_date_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;

  cal_date_t   pending_dates[$];
  int unsigned cycle_count = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_mismatch  = 0;
  int unsigned hold_len    = 0;
  int unsigned stall_left  = 0;
  bit          steady      = 1'b1;

  gregorian_date_add_days_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d dates still owed", cycle_count,
               pending_dates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Calendar rules of the predictor
  function automatic bit is_leap(input logic [YearW-1:0] y);
    int unsigned v;
    v = 32'(y);
    return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
  endfunction

  function automatic int unsigned days_of(input logic [YearW-1:0] y, input int unsigned m);
    if (m == MonthFeb) return 32'(is_leap(y) ? FebLeap : FebPlain);
    case (m)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Form the day of year, add the count, then walk months from January
  function automatic cal_date_t add_days(input date_req_t r);
    logic [YearW-1:0] y;
    int unsigned      mon;
    int unsigned      left;
    cal_date_t        res;
    y   = r.year;
    mon = 32'((r.month > MonthDec) ? MonthDec : r.month);
    left = 32'(r.day);
    for (int unsigned k = 32'(MonthJan); k < mon; k++) left += days_of(y, k);
    left += 32'(r.count);
    mon = 32'(MonthJan);
    while (left > days_of(y, mon)) begin
      left -= days_of(y, mon);
      mon++;
      if (mon > MonthDec) begin
        mon = 32'(MonthJan);
        y   = y + YearW'(1);
      end
    end
    res.year  = y;
    res.month = mon[MonthW-1:0];
    res.day   = left[DayW-1:0];
    return res;
  endfunction

  function automatic date_req_t make_req(input int unsigned y, input int unsigned m,
                                         input int unsigned d, input int unsigned n);
    date_req_t r;
    r.year  = y[YearW-1:0];
    r.month = m[MonthW-1:0];
    r.day   = d[DayW-1:0];
    r.count = n[CountW-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while steady
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random date and count, biased toward legal dates and short walks
  function automatic date_req_t random_req();
    int unsigned y, m, d, n, roll;
    roll = $urandom_range(0, 99);
    if (roll < 50)      y = $urandom_range(1, YearTop);
    else if (roll < 65) y = $urandom_range(1, 99) * 100;
    else if (roll < 87) y = $urandom_range(0, YearMax);
    else                y = $urandom_range(YearMax - 300, YearMax);
    m = ($urandom_range(0, 99) < 85) ? $urandom_range(MonthJan, MonthDec)
                                     : $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 80 && m >= MonthJan && m <= MonthDec)
      d = $urandom_range(1, days_of(y[YearW-1:0], m));
    else
      d = $urandom_range(0, 31);
    roll = $urandom_range(0, 99);
    if (roll < 40)      n = $urandom_range(0, 400);
    else if (roll < 70) n = $urandom_range(0, NormCount);
    else if (roll < 90) n = $urandom_range(0, MaxCount);
    else begin
      case ($urandom_range(0, 2))
        0:       n = 0;
        1:       n = NormCount;
        default: n = MaxCount;
      endcase
    end
    return make_req(y, m, d, n);
  endfunction

  // Offer one beat after an optional gap; leave tvalid high on return
  task automatic send_request(input date_req_t r, input int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r};
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(add_days(r));
    n_sent++;
  endtask

  // Drop tvalid and hold until every owed date has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Receiver: hold-off requests first, then random stalls
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady) begin
        case ($urandom_range(0, 24))
          0, 1, 2, 3: stall_left = $urandom_range(1, 3);
          4:          stall_left = $urandom_range(20, 80);
          default:    stall_left = 0;
        endcase
      end
    end
  end

  // Compare each output beat with the oldest owed date
  always @(posedge clk) begin : check_beat
    cal_date_t got;
    cal_date_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[22:0];
      if (pending_dates.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= ReportMax)
          $display("unexpected beat: %0d-%0d-%0d", got.year, got.month, got.day);
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if (got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || out_tdata[23] !== 1'b0) begin
          n_mismatch++;
          if (n_mismatch <= ReportMax)
            $display("date %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d (pad %b)",
                     n_checked, want.year, want.month, want.day,
                     got.year, got.month, got.day, out_tdata[23]);
        end
      end
    end
  end

  // Edges of the fields and each calendar special case
  task automatic test_directed();
    steady = 1'b1;
    send_request(make_req(1, 1, 1, 0), 0);
    send_request(make_req(YearTop, 12, 31, NormCount), 0);
    send_request(make_req(2000, 2, 28, 1), 0);          // leap by 400
    send_request(make_req(1900, 2, 28, 1), 0);          // century, not leap
    send_request(make_req(2024, 2, 28, 1), 0);
    send_request(make_req(2023, 2, 28, 1), 0);
    send_request(make_req(2023, 12, 31, 1), 0);         // roll into next year
    send_request(make_req(2023, 2, 31, 0), 0);          // day past month end
    send_request(make_req(2023, 4, 31, 400), 0);
    send_request(make_req(2023, 0, 15, 0), 0);          // month zero
    send_request(make_req(2023, 15, 1, 0), 0);          // month saturates
    send_request(make_req(2023, 13, 31, 31), 0);
    send_request(make_req(2023, 6, 15, MaxCount), 0);   // count above normal use
    send_request(make_req(YearMax, 12, 31, 1), 0);      // year wraps to zero
    send_request(make_req(YearMax, 12, 31, 60), 0);     // year zero is leap
    send_request(make_req(YearMax, 1, 1, MaxCount), 0);
    send_request(make_req(2023, 1, 0, 0), 0);           // zero day of year
    send_request(make_req(2023, 0, 0, 0), 0);
    send_request(make_req(2023, 3, 0, 0), 0);
    send_request(make_req(0, 2, 28, 1), 0);
    send_request(make_req(0, 0, 0, 0), 0);
    send_request(make_req(YearMax, 15, 31, MaxCount), 0);
    wait_drained();
  endtask

  // Random dates, first back to back, then with gaps and stalls
  task automatic test_random_traffic();
    steady = 1'b1;
    repeat (60) send_request(random_req(), 0);
    steady = 1'b0;
    repeat (440) send_request(random_req(), pick_gap());
    wait_drained();
  endtask

  // Hold the receiver off so the unit fills and stalls its input
  task automatic test_output_hold_off();
    steady   = 1'b1;
    hold_len = 400;
    repeat (6) send_request(make_req($urandom_range(1, YearTop), $urandom_range(1, 12),
                                     $urandom_range(1, 28), $urandom_range(0, 60)), 0);
    wait_drained();
  endtask

  // Let every result come back before each new beat
  task automatic test_drain_between_items();
    steady = 1'b0;
    repeat (12) begin
      send_request(random_req(), pick_gap());
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_output_hold_off();
    test_drain_between_items();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("sent %0d dates (leap years, year rollover and wrap, out-of-range fields),",
             n_sent);
    $display("checked %0d results, %0d mismatches, %0d cycles", n_checked, n_mismatch,
             cycle_count);
    if (n_mismatch == 0 && pending_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
